FILE: rtl/core/pbsa_pkg.sv
`timescale 1ns / 1ps

package pbsa_pkg;

    typedef enum logic [1:0] {
        CMD_BUS_START    = 2'd0,
        CMD_DEVICE_START = 2'd1,
        CMD_BAR_PROBE    = 2'd2,
        CMD_DEVICE_END   = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_EMPTY   = 2'd1,
        STATUS_WIDE    = 2'd2,
        STATUS_SKIPPED = 2'd3
    } status_t;

    // Configuration register indexes
    localparam logic [1:0] REG_IO_WINDOW_BASE    = 2'd0;
    localparam logic [1:0] REG_MEM_WINDOW_BASE   = 2'd1;
    localparam logic [1:0] REG_IO_FIRST_ADDRESS  = 2'd2;
    localparam logic [1:0] REG_MEM_FIRST_ADDRESS = 2'd3;

    localparam logic TARGET_BAR     = 1'b0;
    localparam logic TARGET_COMMAND = 1'b1;

    // Reset values
    localparam logic [31:0] IO_WINDOW_BASE_RST    = 32'hfe80_0000;
    localparam logic [31:0] MEM_WINDOW_BASE_RST   = 32'hf000_0000;
    localparam logic [31:0] IO_FIRST_ADDRESS_RST  = 32'h0001_0000;
    localparam logic [31:0] MEM_FIRST_ADDRESS_RST = 32'h0200_0000;

    // Command register bits
    localparam logic [15:0] CMDW_IO     = 16'h0001;
    localparam logic [15:0] CMDW_MEM    = 16'h0002;
    localparam logic [15:0] CMDW_MASTER = 16'h0004;

    localparam logic [31:0] IO_MIN_ALIGN  = 32'h0000_0400;
    localparam logic [31:0] MEM_MIN_ALIGN = 32'h0000_1000;
    localparam logic [31:0] BUS_ALIGN     = 32'h0000_1000;
    localparam logic [31:0] IO_BAR_MASK   = 32'h00ff_ffff;

    typedef struct packed {
        command_t    command;
        logic [31:0] probe_value;
        logic [15:0] device_command_word;
        logic        already_configured;
        logic        is_vga_display;
    } in_item_t;

    typedef struct packed {
        logic        write_valid;
        logic        write_target;
        logic [31:0] write_value;
        logic [31:0] resource_start;
        logic        resource_valid;
        status_t     status;
    } out_item_t;

endpackage

FILE: rtl/core/pbsa_stream_if.sv
`timescale 1ns / 1ps

interface pbsa_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/pci_bar_size_and_assign.sv
`timescale 1ns / 1ps
// PCI BAR sizing and bump allocation.
// in_ch carries one enumeration event per transfer: bus start, device start,
// BAR probe (the read-back after writing all ones) or device finish.
// out_ch returns exactly one result per event: an optional config write
// (to the BAR or to the command register), the host address assigned to
// the BAR and a status code.
// The config port (cfg_we, cfg_index, cfg_wdata) sets the host I/O and
// memory window bases; write it only while the block is idle. The first
// address registers only define the reset value of the allocation pointers.
// A result is registered and appears on out_ch in the cycle after its input
// transfer. Throughput: one event per cycle while out_ch is ready. The sizing,
// align-up and pointer add are one combinational pass from the held pointers
// into the output register. When out_ch stalls, the output register holds
// its result and in_ch drops ready; a new transfer is taken in the same cycle
// the held result leaves. Reset clears the pending result, loads the pointers
// with their first addresses, clears the command word and the skip flags, and
// restores the window bases to their defaults.
module pci_bar_size_and_assign (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    pbsa_stream_if.sink   in_ch,
    pbsa_stream_if.source out_ch
);

    // Configuration
    logic [31:0] io_base_reg;
    logic [31:0] mem_base_reg;

    // Allocation state
    logic [31:0] io_ptr_reg, io_ptr_next;
    logic [31:0] mem_ptr_reg, mem_ptr_next;
    logic [15:0] cmd_accum_reg, cmd_accum_next;
    logic        dev_skip_reg, dev_skip_next;
    logic        slot_skip_reg, slot_skip_next;

    // Output register
    logic                 out_valid_reg;
    pbsa_pkg::out_item_t  out_item_reg, out_item_next;

    logic                in_fire;
    pbsa_pkg::in_item_t  item;

    // Probe sizing
    logic [31:0] io_bar, io_size, io_align, io_addr, io_host;
    logic [31:0] mem_bar, mem_size, mem_align, mem_addr, mem_host;
    logic [31:0] io_bus_aligned, mem_bus_aligned;

    assign item      = in_ch.payload;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire   = in_ch.valid && in_ch.ready;

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

    // Config writes; first-address writes have no effect after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            io_base_reg  <= pbsa_pkg::IO_WINDOW_BASE_RST;
            mem_base_reg <= pbsa_pkg::MEM_WINDOW_BASE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pbsa_pkg::REG_IO_WINDOW_BASE:    io_base_reg  <= cfg_wdata;
                pbsa_pkg::REG_MEM_WINDOW_BASE:   mem_base_reg <= cfg_wdata;
                pbsa_pkg::REG_IO_FIRST_ADDRESS,
                pbsa_pkg::REG_MEM_FIRST_ADDRESS: ;
                default: ;
            endcase
        end
    end

    // Sizing: drop the flag bits, take the lowest set bit, align up
    always_comb
    begin
        io_bar   = item.probe_value & ~32'h3;
        io_size  = io_bar & (32'd0 - io_bar);
        io_align = (io_size > pbsa_pkg::IO_MIN_ALIGN) ? io_size : pbsa_pkg::IO_MIN_ALIGN;
        io_addr  = (io_ptr_reg + (io_align - 32'd1)) & ~(io_align - 32'd1);
        io_host  = io_base_reg + io_addr;

        mem_bar   = item.probe_value & ~32'hf;
        mem_size  = mem_bar & (32'd0 - mem_bar);
        mem_align = (mem_size > pbsa_pkg::MEM_MIN_ALIGN) ? mem_size
                                                          : pbsa_pkg::MEM_MIN_ALIGN;
        mem_addr  = (mem_ptr_reg + (mem_align - 32'd1)) & ~(mem_align - 32'd1);
        mem_host  = mem_base_reg + mem_addr;

        io_bus_aligned  = (io_ptr_reg + (pbsa_pkg::BUS_ALIGN - 32'd1))
                          & ~(pbsa_pkg::BUS_ALIGN - 32'd1);
        mem_bus_aligned = (mem_ptr_reg + (pbsa_pkg::BUS_ALIGN - 32'd1))
                          & ~(pbsa_pkg::BUS_ALIGN - 32'd1);
    end

    // Event decode
    always_comb
    begin
        io_ptr_next    = io_ptr_reg;
        mem_ptr_next   = mem_ptr_reg;
        cmd_accum_next = cmd_accum_reg;
        dev_skip_next  = dev_skip_reg;
        slot_skip_next = slot_skip_reg;

        out_item_next                = '0;
        out_item_next.write_target   = pbsa_pkg::TARGET_BAR;
        out_item_next.status         = pbsa_pkg::STATUS_OK;

        unique case (item.command)
            pbsa_pkg::CMD_BUS_START:
            begin
                io_ptr_next  = io_bus_aligned;
                mem_ptr_next = mem_bus_aligned;
            end
            pbsa_pkg::CMD_DEVICE_START:
            begin
                cmd_accum_next = item.device_command_word;
                dev_skip_next  = item.already_configured;
                slot_skip_next = 1'b0;
            end
            pbsa_pkg::CMD_BAR_PROBE:
            begin
                if (dev_skip_reg)
                begin
                    out_item_next.status = pbsa_pkg::STATUS_SKIPPED;
                end
                else if (slot_skip_reg)
                begin
                    slot_skip_next       = 1'b0;
                    out_item_next.status = pbsa_pkg::STATUS_SKIPPED;
                end
                else if (item.probe_value == 32'd0)
                begin
                    out_item_next.resource_valid = 1'b1;
                    out_item_next.status         = pbsa_pkg::STATUS_EMPTY;
                end
                else if (item.probe_value[0])
                begin
                    cmd_accum_next               = cmd_accum_reg | pbsa_pkg::CMDW_IO;
                    io_ptr_next                  = io_addr + io_size;
                    out_item_next.write_valid    = 1'b1;
                    out_item_next.write_value    = (io_host & pbsa_pkg::IO_BAR_MASK)
                                                   | 32'd1;
                    out_item_next.resource_start = io_host | 32'd1;
                    out_item_next.resource_valid = 1'b1;
                end
                else
                begin
                    cmd_accum_next = cmd_accum_reg | pbsa_pkg::CMDW_MEM;
                    if (item.probe_value[2:1] == 2'b10)
                    begin
                        // 64-bit BAR: ignore it and the upper-half slot
                        slot_skip_next       = 1'b1;
                        out_item_next.status = pbsa_pkg::STATUS_WIDE;
                    end
                    else
                    begin
                        mem_ptr_next                 = mem_addr + mem_size;
                        out_item_next.write_valid    = 1'b1;
                        out_item_next.write_value    = mem_host;
                        out_item_next.resource_start = mem_host;
                        out_item_next.resource_valid = 1'b1;
                    end
                end
            end
            pbsa_pkg::CMD_DEVICE_END:
            begin
                if (dev_skip_reg)
                begin
                    out_item_next.status = pbsa_pkg::STATUS_SKIPPED;
                end
                else
                begin
                    out_item_next.write_valid  = 1'b1;
                    out_item_next.write_target = pbsa_pkg::TARGET_COMMAND;
                    out_item_next.write_value  = {16'd0, cmd_accum_reg
                        | pbsa_pkg::CMDW_MASTER
                        | (item.is_vga_display ? pbsa_pkg::CMDW_IO : 16'd0)};
                end
            end
            default: ;
        endcase
    end

    // Advance state on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            io_ptr_reg    <= pbsa_pkg::IO_FIRST_ADDRESS_RST;
            mem_ptr_reg   <= pbsa_pkg::MEM_FIRST_ADDRESS_RST;
            cmd_accum_reg <= '0;
            dev_skip_reg  <= 1'b0;
            slot_skip_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            io_ptr_reg    <= io_ptr_next;
            mem_ptr_reg   <= mem_ptr_next;
            cmd_accum_reg <= cmd_accum_next;
            dev_skip_reg  <= dev_skip_next;
            slot_skip_reg <= slot_skip_next;
        end
    end

    // Output register: load on transfer in, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // Checks
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |-> !in_ch.ready)
        else $error("input taken while result is stalled");

    a_bus_align: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && item.command == pbsa_pkg::CMD_BUS_START
        |=> io_ptr_reg[11:0] == 12'd0 && mem_ptr_reg[11:0] == 12'd0)
        else $error("pointers not 4 KiB aligned after bus start");

    a_bar_write_reports: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.write_valid
        && out_item_reg.write_target == pbsa_pkg::TARGET_BAR
        |-> out_item_reg.resource_valid && out_item_reg.status == pbsa_pkg::STATUS_OK)
        else $error("BAR write without reported resource");

    a_idle_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.write_valid
        |-> out_item_reg.write_value == 32'd0)
        else $error("write value set without a write");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

// Enumeration testbench for the BAR sizing and bump allocation block.
// Events go in on in_ch, one result per event comes back on out_ch. An
// in-bench predictor tracks the pointers, the command word and the skip flags
// and is checked field by field against every result transfer.
module testbench;

    // Memory BAR type field, bits 2:1 of the read-back
    localparam logic [1:0] MEM_TYPE_32   = 2'b00;
    localparam logic [1:0] MEM_TYPE_1M   = 2'b01;
    localparam logic [1:0] MEM_TYPE_64   = 2'b10;
    localparam logic [1:0] MEM_TYPE_RSVD = 2'b11;

    localparam int ITEMS_PER_PHASE = 250;
    localparam int PHASES          = 7;
    localparam int DRAIN_LIMIT     = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    pbsa_stream_if #(.payload_t(pbsa_pkg::in_item_t))  in_ch ();
    pbsa_stream_if #(.payload_t(pbsa_pkg::out_item_t)) out_ch ();

    pci_bar_size_and_assign i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Shadow of the configuration registers. The first-address registers only
    // seed the pointers at reset, and reset happens once, so a later write to
    // them must not move the pointers.
    logic [31:0] io_base_m   = pbsa_pkg::IO_WINDOW_BASE_RST;
    logic [31:0] mem_base_m  = pbsa_pkg::MEM_WINDOW_BASE_RST;
    logic [31:0] io_first_m  = pbsa_pkg::IO_FIRST_ADDRESS_RST;
    logic [31:0] mem_first_m = pbsa_pkg::MEM_FIRST_ADDRESS_RST;

    // Shadow of the allocation state
    logic [31:0] io_next_m   = pbsa_pkg::IO_FIRST_ADDRESS_RST;
    logic [31:0] mem_next_m  = pbsa_pkg::MEM_FIRST_ADDRESS_RST;
    logic [15:0] cmd_word_m  = 16'h0000;
    logic        dev_skip_m  = 1'b0;
    logic        slot_skip_m = 1'b0;

    pbsa_pkg::in_item_t  event_q[$];      // events waiting for the driver
    pbsa_pkg::out_item_t want_q[$];       // predicted results, oldest first
    pbsa_pkg::out_item_t due;

    int unsigned n_queued     = 0;
    int unsigned offered_cnt  = 0;
    int unsigned accepted_cnt = 0;
    int unsigned results_cnt  = 0;
    int unsigned mismatches   = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;
    bit          calm         = 1'b0;   // no idling on either side

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [31:0] round_up(logic [31:0] v, logic [31:0] a);
        return (v + (a - 32'd1)) & ~(a - 32'd1);
    endfunction

    // Advance the shadow state by one event and return the result it causes.
    function automatic pbsa_pkg::out_item_t allocate(input pbsa_pkg::in_item_t ev);
        pbsa_pkg::out_item_t r;
        logic [31:0] base;
        logic [31:0] size;
        logic [31:0] align;
        logic [31:0] addr;
        logic [31:0] host;
        r = '0;
        r.status = pbsa_pkg::STATUS_OK;
        r.write_target = pbsa_pkg::TARGET_BAR;
        case (ev.command)
            pbsa_pkg::CMD_BUS_START:
            begin
                io_next_m  = round_up(io_next_m, pbsa_pkg::BUS_ALIGN);
                mem_next_m = round_up(mem_next_m, pbsa_pkg::BUS_ALIGN);
            end
            pbsa_pkg::CMD_DEVICE_START:
            begin
                cmd_word_m  = ev.device_command_word;
                dev_skip_m  = ev.already_configured;
                slot_skip_m = 1'b0;
            end
            pbsa_pkg::CMD_BAR_PROBE:
            begin
                if (dev_skip_m)
                begin
                    r.status = pbsa_pkg::STATUS_SKIPPED;
                end
                else if (slot_skip_m)
                begin
                    // upper half of a 64-bit BAR
                    slot_skip_m = 1'b0;
                    r.status = pbsa_pkg::STATUS_SKIPPED;
                end
                else if (ev.probe_value == 32'd0)
                begin
                    r.resource_valid = 1'b1;
                    r.status = pbsa_pkg::STATUS_EMPTY;
                end
                else if (ev.probe_value[0])
                begin
                    base  = ev.probe_value & ~32'h3;
                    size  = base & (~base + 32'd1);
                    align = (size > pbsa_pkg::IO_MIN_ALIGN) ? size : pbsa_pkg::IO_MIN_ALIGN;
                    addr  = round_up(io_next_m, align);
                    host  = io_base_m + addr;
                    cmd_word_m = cmd_word_m | pbsa_pkg::CMDW_IO;
                    io_next_m  = addr + size;
                    r.write_valid    = 1'b1;
                    r.write_value    = (host & pbsa_pkg::IO_BAR_MASK) | 32'd1;
                    r.resource_start = host | 32'd1;
                    r.resource_valid = 1'b1;
                end
                else
                begin
                    cmd_word_m = cmd_word_m | pbsa_pkg::CMDW_MEM;
                    if (ev.probe_value[2:1] == MEM_TYPE_64)
                    begin
                        slot_skip_m = 1'b1;
                        r.status = pbsa_pkg::STATUS_WIDE;
                    end
                    else
                    begin
                        base  = ev.probe_value & ~32'hf;
                        size  = base & (~base + 32'd1);
                        align = (size > pbsa_pkg::MEM_MIN_ALIGN) ? size
                                                                 : pbsa_pkg::MEM_MIN_ALIGN;
                        addr  = round_up(mem_next_m, align);
                        host  = mem_base_m + addr;
                        mem_next_m = addr + size;
                        r.write_valid    = 1'b1;
                        r.write_value    = host;
                        r.resource_start = host;
                        r.resource_valid = 1'b1;
                    end
                end
            end
            default:
            begin
                if (dev_skip_m)
                begin
                    r.status = pbsa_pkg::STATUS_SKIPPED;
                end
                else
                begin
                    r.write_valid  = 1'b1;
                    r.write_target = pbsa_pkg::TARGET_COMMAND;
                    r.write_value  = {16'h0000, cmd_word_m | pbsa_pkg::CMDW_MASTER
                                     | (ev.is_vga_display ? pbsa_pkg::CMDW_IO : 16'h0000)};
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected 0x%08h, got 0x%08h",
                         results_cnt, name, want, got);
        end
    endtask

    task automatic check_result(pbsa_pkg::out_item_t want, pbsa_pkg::out_item_t got);
        check_field("write_valid", 32'(want.write_valid), 32'(got.write_valid));
        check_field("write_target", 32'(want.write_target), 32'(got.write_target));
        check_field("write_value", want.write_value, got.write_value);
        check_field("resource_start", want.resource_start, got.resource_start);
        check_field("resource_valid", 32'(want.resource_valid), 32'(got.resource_valid));
        check_field("status", 32'(want.status), 32'(got.status));
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic pbsa_pkg::in_item_t make_event(pbsa_pkg::command_t c,
                                                      logic [31:0] probe,
                                                      logic [15:0] word, logic done,
                                                      logic vga);
        pbsa_pkg::in_item_t ev;
        ev.command             = c;
        ev.probe_value         = probe;
        ev.device_command_word = word;
        ev.already_configured  = done;
        ev.is_vga_display      = vga;
        return ev;
    endfunction

    task automatic offer(pbsa_pkg::in_item_t ev);
        event_q.push_back(ev);
        n_queued++;
    endtask

    // Build a BAR read-back: mostly realistic all-ones-above-size patterns,
    // with small sizes favored and the odd huge one to wrap the pointers.
    function automatic logic [31:0] bar_readback();
        int unsigned pick;
        int unsigned k;
        logic [31:0] mask;
        logic [31:0] v;
        logic [1:0]  kind;
        pick = $urandom_range(0, 99);
        k    = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 31) : $urandom_range(2, 16);
        mask = ~((32'd1 << k) - 32'd1);
        if (pick < 8)
        begin
            v = 32'd0;
        end
        else if (pick < 35)
        begin
            v = mask | 32'd1;
            v[1] = 1'($urandom_range(0, 1));
            // some I/O BARs decode only 16 bits
            if ($urandom_range(0, 3) == 0)
                v[31:16] = 16'h0000;
        end
        else if (pick < 72)
        begin
            case ($urandom_range(0, 2))
                0:       kind = MEM_TYPE_32;
                1:       kind = MEM_TYPE_1M;
                default: kind = MEM_TYPE_RSVD;
            endcase
            v = mask & ~32'hf;
            v[2:1] = kind;
            v[3] = 1'($urandom_range(0, 1));
        end
        else if (pick < 86)
        begin
            v = mask & ~32'hf;
            v[2:1] = MEM_TYPE_64;
            v[3] = 1'($urandom_range(0, 1));
        end
        else
        begin
            v = $urandom;
        end
        return v;
    endfunction

    // One device: optional bus start, device start, a few BARs, finish.
    // Fields an event does not use carry random bits.
    task automatic queue_device();
        int unsigned n;
        if ($urandom_range(0, 5) == 0)
            offer(make_event(pbsa_pkg::CMD_BUS_START, $urandom, 16'($urandom),
                             1'($urandom), 1'($urandom)));
        offer(make_event(pbsa_pkg::CMD_DEVICE_START, $urandom, 16'($urandom),
                         1'($urandom_range(0, 4) == 0), 1'($urandom)));
        n = $urandom_range(0, 6);
        repeat (n)
            offer(make_event(pbsa_pkg::CMD_BAR_PROBE, bar_readback(), 16'($urandom),
                             1'($urandom), 1'($urandom)));
        offer(make_event(pbsa_pkg::CMD_DEVICE_END, $urandom, 16'($urandom),
                         1'($urandom), 1'($urandom)));
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            pbsa_pkg::REG_IO_WINDOW_BASE:   io_base_m   = val;
            pbsa_pkg::REG_MEM_WINDOW_BASE:  mem_base_m  = val;
            pbsa_pkg::REG_IO_FIRST_ADDRESS: io_first_m  = val;
            default:                        mem_first_m = val;
        endcase
    endtask

    // Wait until every queued event has been taken and every result has come, or DRAIN_LIMIT runs out.
    task automatic drain();
        int unsigned guard;
        guard = 0;
        while ((event_q.size() != 0 || accepted_cnt != offered_cnt || want_q.size() != 0)
               && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and the run
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : stimulus
        logic [31:0] vals [4];
        int unsigned goal;
        // Drive every input to a known value before reset lets go.
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = pbsa_pkg::REG_IO_WINDOW_BASE;
        cfg_wdata      = 32'd0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        out_ch.ready   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed opening, reset configuration.
        // A probe with no device start yet uses the reset state as it is.
        offer(make_event(pbsa_pkg::CMD_BAR_PROBE, 32'hffff_f001, 16'h0000, 1'b0, 1'b0));
        offer(make_event(pbsa_pkg::CMD_BUS_START, 32'h0000_0000, 16'h0000, 1'b0, 1'b0));
        offer(make_event(pbsa_pkg::CMD_DEVICE_START, 32'h0000_0000, 16'h0000, 1'b0, 1'b0));
        // empty
        offer(make_event(pbsa_pkg::CMD_BAR_PROBE, 32'h0000_0000, 16'h0000, 1'b0, 1'b0));
        // tiny I/O
        offer(make_event(pbsa_pkg::CMD_BAR_PROBE, 32'hffff_ffff, 16'hffff, 1'b1, 1'b1));
        // I/O, no size
        offer(make_event(pbsa_pkg::CMD_BAR_PROBE, 32'h0000_0001, 16'h0000, 1'b0, 1'b0));
        // 2 GiB I/O
        offer(make_event(pbsa_pkg::CMD_BAR_PROBE, 32'h8000_0001, 16'h0000, 1'b0, 1'b0));
        // tiny memory
        offer(make_event(pbsa_pkg::CMD_BAR_PROBE, 32'hffff_fff0, 16'h0000, 1'b0, 1'b0));
        // prefetchable
        offer(make_event(pbsa_pkg::CMD_BAR_PROBE, 32'hfff0_0008, 16'h0000, 1'b0, 1'b0));
        // 2 GiB memory
        offer(make_event(pbsa_pkg::CMD_BAR_PROBE, 32'h8000_0000, 16'h0000, 1'b0, 1'b0));
        // 64-bit
        offer(make_event(pbsa_pkg::CMD_BAR_PROBE, 32'hffff_fff4, 16'h0000, 1'b0, 1'b0));
        // its upper half
        offer(make_event(pbsa_pkg::CMD_BAR_PROBE, 32'hffff_ffff, 16'h0000, 1'b0, 1'b0));
        // below 1M type
        offer(make_event(pbsa_pkg::CMD_BAR_PROBE, 32'hffff_0002, 16'h0000, 1'b0, 1'b0));
        // reserved type
        offer(make_event(pbsa_pkg::CMD_BAR_PROBE, 32'hffff_0006, 16'h0000, 1'b0, 1'b0));
        // memory, no size
        offer(make_event(pbsa_pkg::CMD_BAR_PROBE, 32'h0000_000e, 16'h0000, 1'b0, 1'b0));
        // VGA finish
        offer(make_event(pbsa_pkg::CMD_DEVICE_END, 32'hffff_ffff, 16'hffff, 1'b1, 1'b1));
        // configured
        offer(make_event(pbsa_pkg::CMD_DEVICE_START, 32'hffff_ffff, 16'hffff, 1'b1, 1'b1));
        offer(make_event(pbsa_pkg::CMD_BAR_PROBE, 32'hffff_f001, 16'h0000, 1'b0, 1'b0));
        offer(make_event(pbsa_pkg::CMD_DEVICE_END, 32'h0000_0000, 16'h0000, 1'b0, 1'b0));
        offer(make_event(pbsa_pkg::CMD_DEVICE_START, 32'h0000_0000, 16'h0400, 1'b0, 1'b0));
        // 64-bit
        offer(make_event(pbsa_pkg::CMD_BAR_PROBE, 32'hffff_fffc, 16'h0000, 1'b0, 1'b0));
        // flag pending
        offer(make_event(pbsa_pkg::CMD_DEVICE_END, 32'h0000_0000, 16'h0000, 1'b0, 1'b0));
        // clears it
        offer(make_event(pbsa_pkg::CMD_DEVICE_START, 32'h0000_0000, 16'h0000, 1'b0, 1'b0));
        // 256 B I/O
        offer(make_event(pbsa_pkg::CMD_BAR_PROBE, 32'hffff_ff01, 16'h0000, 1'b0, 1'b0));
        offer(make_event(pbsa_pkg::CMD_BUS_START, 32'h0000_0000, 16'h0000, 1'b0, 1'b0));
        offer(make_event(pbsa_pkg::CMD_DEVICE_END, 32'h0000_0000, 16'h0000, 1'b0, 1'b1));

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                // Settle the block before touching the windows.
                drain();
                repeat (2) @(posedge clk);
                case (p)
                    1:
                    begin
                        vals = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
                    end
                    2:
                    begin
                        vals = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
                    end
                    PHASES - 1:
                    begin
                        vals = '{pbsa_pkg::IO_WINDOW_BASE_RST, pbsa_pkg::MEM_WINDOW_BASE_RST,
                                 pbsa_pkg::IO_FIRST_ADDRESS_RST,
                                 pbsa_pkg::MEM_FIRST_ADDRESS_RST};
                    end
                    default:
                    begin
                        vals = '{$urandom, $urandom, $urandom, $urandom};
                    end
                endcase
                write_reg(pbsa_pkg::REG_IO_WINDOW_BASE, vals[0]);
                write_reg(pbsa_pkg::REG_MEM_WINDOW_BASE, vals[1]);
                write_reg(pbsa_pkg::REG_IO_FIRST_ADDRESS, vals[2]);
                write_reg(pbsa_pkg::REG_MEM_FIRST_ADDRESS, vals[3]);
                @(negedge clk);
                cfg_we <= 1'b0;
            end
            // Run the last phase flat out on both sides.
            if (p == PHASES - 1)
                calm = 1'b1;
            goal = n_queued + ITEMS_PER_PHASE;
            while (n_queued < goal)
            begin
                if ($urandom_range(0, 9) == 0)
                    offer(make_event(pbsa_pkg::command_t'($urandom_range(0, 3)), $urandom,
                                     16'($urandom), 1'($urandom), 1'($urandom)));
                else
                    queue_device();
            end
        end

        drain();
        // Anything still outstanding never came back.
        while (want_q.size() != 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("expected result never arrived: value 0x%08h status %0d",
                         want_q[0].write_value, want_q[0].status);
            void'(want_q.pop_front());
        end
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: generous against the slowest legal run.
    initial
    begin
        #10ms;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: change inputs on the falling edge
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && accepted_cnt != offered_cnt)
            begin
                // hold the current event until its transfer
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end
            else if (event_q.size() > 0)
            begin
                in_ch.payload <= event_q.pop_front();
                in_ch.valid   <= 1'b1;
                offered_cnt++;
                // occasionally drop valid for a burst after this event
                if (!calm && $urandom_range(0, 7) == 0)
                    gap_left = $urandom_range(1, 15);
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result-side ready: random stall bursts, plus one long hold-off once
    // traffic is flowing so the output register fills and in_ch backs up.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (!hold_done && results_cnt >= 400)
            begin
                hold_done = 1'b1;
                hold_left = 300;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 15);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge
    // ------------------------------------------------------------------

    // Predict before checking so the order within the edge never matters.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                want_q.push_back(allocate(in_ch.payload));
                accepted_cnt++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                results_cnt++;
                if (want_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing outstanding: value 0x%08h",
                                 results_cnt, out_ch.payload.write_value);
                end
                else
                begin
                    due = want_q.pop_front();
                    check_result(due, out_ch.payload);
                end
            end
        end
    end

endmodule
